### sv/tsmcd_pkg.sv
package tsmcd_pkg;

    localparam int MAX_SAMPLES = 1024;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int VALUE_W     = 32;
    localparam int LABEL_W     = 2;
    localparam int ENTRY_W     = VALUE_W + LABEL_W;
    localparam int PROD_W      = 2 * CNT_W;
    localparam int FRAC_W      = 16;
    localparam int DIFF_W      = FRAC_W + 1;
    localparam int NUM_W       = PROD_W + FRAC_W;
    localparam int OUT_DATA_W  = 48;

    localparam logic [LABEL_W-1:0] LABEL_CLASS_A = 2'd1;
    localparam logic [LABEL_W-1:0] LABEL_CLASS_B = 2'd0;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_PIVOT_RD,
        ST_PIVOT_LAT,
        ST_SCAN,
        ST_DRAIN,
        ST_MUL,
        ST_CMP,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic start;
        logic done;
    } div_ctrl_t;

endpackage

### sv/tsmcd_store.sv
module tsmcd_store (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [tsmcd_pkg::ADDR_W-1:0]  wr_addr,
    input  logic [tsmcd_pkg::ENTRY_W-1:0] wr_data,
    input  logic [tsmcd_pkg::ADDR_W-1:0]  rd_addr,
    output logic [tsmcd_pkg::ENTRY_W-1:0] rd_data
);
    import tsmcd_pkg::*;

    logic [ENTRY_W-1:0] mem [MAX_SAMPLES];
    logic [ENTRY_W-1:0] rd_data_reg;

    // write one word, read one word with a registered output
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/tsmcd_divider.sv
module tsmcd_divider (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  tsmcd_pkg::div_ctrl_t           ctrl_in,
    output tsmcd_pkg::div_ctrl_t           ctrl_out,
    input  logic [tsmcd_pkg::NUM_W-1:0]    num,
    input  logic [tsmcd_pkg::PROD_W-1:0]   den,
    output logic [tsmcd_pkg::DIFF_W-1:0]   quot
);
    import tsmcd_pkg::*;

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic [PROD_W:0]   rem_reg, rem_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [NUM_W-1:0]  q_reg, q_next;
    logic [PROD_W-1:0] den_reg, den_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [PROD_W:0]   trial;

    // one quotient bit per cycle, restoring
    always_comb begin
        rem_next  = rem_reg;
        num_next  = num_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[PROD_W-1:0], num_reg[NUM_W-1]};
        if (ctrl_in.start) begin
            rem_next  = '0;
            num_next  = num;
            q_next    = '0;
            den_next  = den;
            step_next = STEP_W'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            num_next = {num_reg[NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg}) begin
                rem_next = trial - {1'b0, den_reg};
                q_next   = {q_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next = trial;
                q_next   = {q_reg[NUM_W-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        rem_reg <= rem_next;
        num_reg <= num_next;
        q_reg   <= q_next;
        den_reg <= den_next;
    end

    // clamp to 1.0
    always_comb begin
        if (q_reg > NUM_W'(1 << FRAC_W)) begin
            quot = DIFF_W'(1 << FRAC_W);
        end else begin
            quot = q_reg[DIFF_W-1:0];
        end
    end

    assign ctrl_out.start = busy_reg;
    assign ctrl_out.done  = done_reg;

endmodule

### sv/two_sample_max_cdf_difference.sv
// After the last word the scan takes each stored sample in turn as the threshold and
// reads the whole memory once through its single read port; then the divider runs.
// Throughput: one input word per cycle while loading; no input during scan/output.
// Reset: aresetn (synchronous, active low) clears the sample and class counts, the
// overflow flag and the control state; the sample memory holds no reset value.
module two_sample_max_cdf_difference (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // sample_value[31:0]
    input  logic [1:0]  s_tuser,   // class_label[1:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // max_difference[16:0], count_class_a[27:17],
                                   // count_class_b[38:28], class_empty[39],
                                   // overflowed[40], zero[47:41]
);
    import tsmcd_pkg::*;

    ctrl_state_t         state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                ovf_reg, ovf_next;
    logic [CNT_W-1:0]    ta_reg, ta_next, tb_reg, tb_next;
    logic [CNT_W-1:0]    ca_reg, ca_next, cb_reg, cb_next;
    logic [CNT_W-1:0]    i_reg, i_next, j_reg, j_next;
    logic                rd_vld_reg, rd_vld_next;
    logic [VALUE_W-1:0]  pivot_reg, pivot_next;
    logic [PROD_W-1:0]   p_reg, p_next, q_reg, q_next;
    logic [PROD_W-1:0]   best_reg, best_next;
    logic [PROD_W-1:0]   diff;
    logic [DIFF_W-1:0]   res_diff_reg, res_diff_next;
    logic                empty_reg, empty_next;
    logic                wr_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0]  rd_data;
    logic [PROD_W-1:0]   den;
    logic [NUM_W-1:0]    num;
    logic [DIFF_W-1:0]   quot;
    div_ctrl_t           div_in, div_out;
    logic                accept;

    assign accept = s_tvalid && s_tready;
    assign wr_en  = accept && (cnt_reg < CNT_W'(MAX_SAMPLES));

    tsmcd_store u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (cnt_reg[ADDR_W-1:0]),
        .wr_data ({s_tuser, s_tdata}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign den = ta_reg * tb_reg;
    assign num = {best_reg, FRAC_W'(0)} + NUM_W'(den >> 1);

    tsmcd_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl_in  (div_in),
        .ctrl_out (div_out),
        .num      (num),
        .den      (den),
        .quot     (quot)
    );

    assign diff = (p_reg > q_reg) ? (p_reg - q_reg) : (q_reg - p_reg);

    // sequence load, threshold scan, divide and output
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        ovf_next      = ovf_reg;
        ta_next       = ta_reg;
        tb_next       = tb_reg;
        ca_next       = ca_reg;
        cb_next       = cb_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        rd_vld_next   = 1'b0;
        pivot_next    = pivot_reg;
        p_next        = p_reg;
        q_next        = q_reg;
        best_next     = best_reg;
        res_diff_next = res_diff_reg;
        empty_next    = empty_reg;
        div_in.start  = 1'b0;
        div_in.done   = 1'b0;
        s_tready      = 1'b0;
        rd_addr       = j_reg[ADDR_W-1:0];
        case (state_reg)
            ST_LOAD: begin
                s_tready = 1'b1;
                if (accept) begin
                    if (wr_en) begin
                        cnt_next = cnt_reg + 1'b1;
                        if (s_tuser == LABEL_CLASS_A) ta_next = ta_reg + 1'b1;
                        else if (s_tuser == LABEL_CLASS_B) tb_next = tb_reg + 1'b1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast) begin
                        i_next    = '0;
                        best_next = '0;
                        if (ta_next == '0 || tb_next == '0) begin
                            empty_next    = 1'b1;
                            res_diff_next = '0;
                            state_next    = ST_OUT;
                        end else begin
                            empty_next = 1'b0;
                            state_next = ST_PIVOT_RD;
                        end
                    end
                end
            end
            ST_PIVOT_RD: begin
                rd_addr    = i_reg[ADDR_W-1:0];
                state_next = ST_PIVOT_LAT;
            end
            ST_PIVOT_LAT: begin
                pivot_next = rd_data[VALUE_W-1:0];
                ca_next    = '0;
                cb_next    = '0;
                j_next     = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN, ST_DRAIN: begin
                // count each class A or class B sample at or above the threshold
                if (rd_vld_reg &&
                    $signed(rd_data[VALUE_W-1:0]) >= $signed(pivot_reg)) begin
                    if (rd_data[ENTRY_W-1:VALUE_W] == LABEL_CLASS_A) begin
                        ca_next = ca_reg + 1'b1;
                    end else if (rd_data[ENTRY_W-1:VALUE_W] == LABEL_CLASS_B) begin
                        cb_next = cb_reg + 1'b1;
                    end
                end
                if (state_reg == ST_SCAN) begin
                    rd_vld_next = 1'b1;
                    j_next      = j_reg + 1'b1;
                    if (j_reg == cnt_reg - 1'b1) state_next = ST_DRAIN;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                p_next     = ca_reg * tb_reg;
                q_next     = cb_reg * ta_reg;
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (diff > best_reg) best_next = diff;
                i_next = i_reg + 1'b1;
                if (i_reg == cnt_reg - 1'b1) state_next = ST_DIV_START;
                else state_next = ST_PIVOT_RD;
            end
            ST_DIV_START: begin
                div_in.start = 1'b1;
                state_next   = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_out.done) begin
                    res_diff_next = quot;
                    state_next    = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    cnt_next   = '0;
                    ovf_next   = 1'b0;
                    ta_next    = '0;
                    tb_next    = '0;
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // hold control state and payload
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_LOAD;
            cnt_reg    <= '0;
            ovf_reg    <= 1'b0;
            ta_reg     <= '0;
            tb_reg     <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            ovf_reg    <= ovf_next;
            ta_reg     <= ta_next;
            tb_reg     <= tb_next;
            rd_vld_reg <= rd_vld_next;
        end
        ca_reg       <= ca_next;
        cb_reg       <= cb_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        pivot_reg    <= pivot_next;
        p_reg        <= p_next;
        q_reg        <= q_next;
        best_reg     <= best_next;
        res_diff_reg <= res_diff_next;
        empty_reg    <= empty_next;
    end

    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {7'd0, ovf_reg, empty_reg, tb_reg, ta_reg, res_diff_reg};

    a_no_load_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input taken while result pending");
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_SAMPLES))
        else $error("sample count beyond capacity");
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && empty_reg) |-> (res_diff_reg == '0))
        else $error("empty class with nonzero difference");
    a_class_total: assert property (@(posedge aclk) disable iff (!aresetn)
        (ta_reg + tb_reg) <= cnt_reg)
        else $error("class totals exceed stored count");

endmodule

### sim/two_sample_max_cdf_difference_tb.sv
`timescale 1ns / 100ps

module two_sample_max_cdf_difference_tb;
    import tsmcd_pkg::*;

    typedef struct {
        logic [DIFF_W-1:0] max_diff;
        logic [10:0]       cnt_a;
        logic [10:0]       cnt_b;
        logic              empty;
        logic              ovf;
    } ks_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;    // sample_value[31:0]
    logic [1:0]  s_tuser;    // class_label[1:0]
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;    // max_difference[16:0], count_class_a[27:17],
                             // count_class_b[38:28], class_empty[39], overflowed[40]

    // model of the data set being loaded
    logic [31:0]        set_value [MAX_SAMPLES];
    logic [LABEL_W-1:0] set_label [MAX_SAMPLES];
    int                 set_count;
    logic               set_dropped;

    ks_result_t ks_expected_q[$];
    int  mismatch_count;
    bit  sink_no_idle;
    bit  sink_long_hold;
    int  n_items;

    two_sample_max_cdf_difference i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Sort the closed set by value (descending) and scan the groups of equal values.
    function automatic ks_result_t ks_statistic();
        logic [31:0]        v [MAX_SAMPLES];
        logic [LABEL_W-1:0] l [MAX_SAMPLES];
        logic [31:0]        tv;
        logic [LABEL_W-1:0] tl;
        longint             ta, tb, ca, cb, best, p, q, dif, den;
        int                 j;
        ks_result_t         r;
        ta = 0; tb = 0; ca = 0; cb = 0; best = 0;
        for (int i = 0; i < set_count; i++) begin
            v[i] = set_value[i];
            l[i] = set_label[i];
            if (l[i] == LABEL_CLASS_A) ta++;
            else if (l[i] == LABEL_CLASS_B) tb++;
        end
        for (int i = 1; i < set_count; i++) begin
            tv = v[i]; tl = l[i]; j = i;
            while (j > 0 && $signed(v[j-1]) < $signed(tv)) begin
                v[j] = v[j-1]; l[j] = l[j-1]; j--;
            end
            v[j] = tv; l[j] = tl;
        end
        r.empty = (ta == 0 || tb == 0);
        if (!r.empty) begin
            for (int i = 0; i < set_count; i++) begin
                if (l[i] == LABEL_CLASS_A) ca++;
                else if (l[i] == LABEL_CLASS_B) cb++;
                if (i + 1 == set_count || v[i+1] != v[i]) begin
                    p = ca * tb; q = cb * ta;
                    dif = (p > q) ? p - q : q - p;
                    if (dif > best) best = dif;
                end
            end
            den  = ta * tb;
            best = (best * 65536 + den / 2) / den;
            if (best > 65536) best = 65536;
        end
        r.max_diff = best[DIFF_W-1:0];
        r.cnt_a    = ta[10:0];
        r.cnt_b    = tb[10:0];
        r.ovf      = set_dropped;
        return r;
    endfunction

    // Offer one word after a random gap; keep tvalid high when there is no gap.
    task automatic send_sample(input logic [31:0] value, input logic [1:0] label,
                               input logic last);
        int gap;
        gap = $urandom_range(0, 17);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= label;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        n_items++;
        if (set_count < MAX_SAMPLES) begin
            set_value[set_count] = value;
            set_label[set_count] = label;
            set_count++;
        end else begin
            set_dropped = 1'b1;
        end
        if (last) begin
            ks_expected_q.insert(ks_expected_q.size(), ks_statistic());
            set_count   = 0;
            set_dropped = 1'b0;
        end
    endtask

    task automatic release_input();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    // Random content with a chosen value spread; narrow spreads force ties.
    task automatic send_random_set(input int n, input int spread);
        logic [31:0] value;
        for (int i = 0; i < n; i++) begin
            if (spread == 0) value = $urandom();
            else value = $urandom_range(0, spread) - spread / 2;
            send_sample(value, ($urandom_range(0, 5) == 0) ? 2'($urandom_range(2, 3))
                                                          : 2'($urandom_range(0, 1)),
                        i == n - 1);
        end
    endtask

    task automatic test_directed();
        // full separation across the value extremes: D = 1.0
        send_sample(32'h7FFF_FFFF, LABEL_CLASS_A, 1'b0);
        send_sample(32'h8000_0000, LABEL_CLASS_B, 1'b1);
        // reversed order
        send_sample(32'h8000_0000, LABEL_CLASS_A, 1'b0);
        send_sample(32'h7FFF_FFFF, LABEL_CLASS_B, 1'b1);
        // all values equal: one group, D = 0
        send_sample(32'h0000_0000, LABEL_CLASS_A, 1'b0);
        send_sample(32'h0000_0000, LABEL_CLASS_B, 1'b0);
        send_sample(32'h0000_0000, LABEL_CLASS_A, 1'b1);
        // class B empty, ignored labels present
        send_sample(32'hFFFF_FFFF, LABEL_CLASS_A, 1'b0);
        send_sample(32'h0001_0000, 2'd2, 1'b0);
        send_sample(32'h5555_5555, 2'd3, 1'b1);
        // only ignored labels
        send_sample(32'hAAAA_AAAA, 2'd3, 1'b1);
        // single sample of class B
        send_sample(32'h0000_0001, LABEL_CLASS_B, 1'b1);
        // ties across classes with an ignored label inside one group
        send_sample(32'd5, LABEL_CLASS_A, 1'b0);
        send_sample(32'd5, 2'd2, 1'b0);
        send_sample(32'd5, LABEL_CLASS_B, 1'b0);
        send_sample(32'd3, LABEL_CLASS_A, 1'b0);
        send_sample(32'hFFFF_FFFD, LABEL_CLASS_B, 1'b0);
        send_sample(32'd3, LABEL_CLASS_A, 1'b0);
        send_sample(32'hFFFF_FFFD, LABEL_CLASS_B, 1'b1);
        // thirds, exercises rounding
        send_sample(32'd9, LABEL_CLASS_A, 1'b0);
        send_sample(32'd8, LABEL_CLASS_B, 1'b0);
        send_sample(32'd7, LABEL_CLASS_B, 1'b0);
        send_sample(32'd6, LABEL_CLASS_A, 1'b0);
        send_sample(32'd5, LABEL_CLASS_A, 1'b1);
    endtask

    // Fill storage and push three more words, the last one closing the set.
    task automatic test_overflow();
        for (int i = 0; i < MAX_SAMPLES + 3; i++)
            send_sample($urandom_range(0, 4000), 2'($urandom_range(0, 1)),
                        i == MAX_SAMPLES + 2);
    endtask

    task automatic test_random();
        int start;
        start = n_items;
        while (n_items - start < 450) begin
            sink_no_idle = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 2))
                0: send_random_set($urandom_range(1, 12), 0);
                1: send_random_set($urandom_range(2, 12), 6);
                default: send_random_set($urandom_range(2, 12), 40);
            endcase
        end
        sink_no_idle = 1'b0;
    endtask

    // Hold the sink off so the next sets back up against the input.
    task automatic test_backpressure();
        sink_long_hold = 1'b1;
        for (int k = 0; k < 4; k++) send_random_set($urandom_range(2, 6), 8);
    endtask

    // sink: random stalls, occasional long hold-off
    initial begin
        int stall;
        m_tready <= 1'b0;
        forever begin
            stall = sink_no_idle ? 0 : $urandom_range(0, 17);
            if (sink_long_hold) begin
                stall = 600;
                sink_long_hold = 1'b0;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // check each result word against the oldest expectation
    always @(posedge aclk) begin
        ks_result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (ks_expected_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result word %h", m_tdata);
            end else begin
                e = ks_expected_q.pop_front();
                if (m_tdata[16:0] !== e.max_diff || m_tdata[27:17] !== e.cnt_a ||
                    m_tdata[38:28] !== e.cnt_b || m_tdata[39] !== e.empty ||
                    m_tdata[40] !== e.ovf) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp diff=%0d a=%0d b=%0d empty=%b ovf=%b, got %h",
                                 e.max_diff, e.cnt_a, e.cnt_b, e.empty, e.ovf, m_tdata);
                end
            end
        end
    end

    initial begin
        #40ms;
        $display("FAILURE");
        $finish;
    end

    initial begin
        int wait_cycles;
        aresetn        <= 1'b0;
        s_tvalid       <= 1'b0;
        s_tdata        <= '0;
        s_tuser        <= '0;
        s_tlast        <= 1'b0;
        set_count      = 0;
        set_dropped    = 1'b0;
        mismatch_count = 0;
        n_items        = 0;
        sink_no_idle   = 1'b0;
        sink_long_hold = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_backpressure();
        test_random();
        test_overflow();
        release_input();

        // drain, then keep watching for stray output
        wait_cycles = 0;
        while (ks_expected_q.size() != 0 && wait_cycles < 2000000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (200) @(posedge aclk);
        if (mismatch_count == 0 && ks_expected_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### sim.f
sv/tsmcd_pkg.sv
sv/tsmcd_store.sv
sv/tsmcd_divider.sv
sv/two_sample_max_cdf_difference.sv
sim/two_sample_max_cdf_difference_tb.sv
